/* sv/tfnm_pkg.sv */
// Package with types, constants and helpers for the tetrahedral face matcher.
`default_nettype none
package tfnm_pkg;

  localparam int unsigned NodeBits = 16;
  localparam int unsigned FaceBits = 18;
  localparam int unsigned MaxFaces = 262144;
  localparam int unsigned CellBits = 16;

  localparam logic [1:0] StatusNew    = 2'd0;
  localparam logic [1:0] StatusMatch  = 2'd1;
  localparam logic [1:0] StatusFull   = 2'd2;
  localparam logic [1:0] StatusShared = 2'd3;

  typedef struct packed {
    logic [15:0] cell_number;
    logic [15:0] vertex_a;
    logic [15:0] vertex_b;
    logic [15:0] vertex_c;
    logic [15:0] vertex_d;
  } in_item_t;

  typedef struct packed {
    logic [15:0] own_cell;
    logic [1:0]  own_slot;
    logic [1:0]  face_status;
    logic [15:0] other_cell;
    logic [1:0]  other_slot;
    logic        last_face;
  } out_item_t;

  // Chain link: valid bit plus face index.
  typedef struct packed {
    logic                vld;
    logic [FaceBits-1:0] idx;
  } link_t;

  // One face table entry.
  typedef struct packed {
    logic [15:0]         v0;
    logic [15:0]         v1;
    logic [15:0]         v2;
    logic [CellBits-1:0] owner_cell;
    logic [1:0]          slot;
    logic                shared;
    link_t               next;
  } face_ent_t;

  // Local vertex index of position k of face slot s.
  function automatic logic [1:0] face_vtx(input logic [1:0] s, input logic [1:0] k);
    logic [1:0] r;
    r = 2'd0;
    unique case ({s, k})
      4'b0000: r = 2'd1;
      4'b0001: r = 2'd2;
      4'b0010: r = 2'd3;
      4'b0100: r = 2'd0;
      4'b0101: r = 2'd3;
      4'b0110: r = 2'd2;
      4'b1000: r = 2'd0;
      4'b1001: r = 2'd1;
      4'b1010: r = 2'd3;
      4'b1100: r = 2'd0;
      4'b1101: r = 2'd2;
      4'b1110: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/tfnm_bucket_ram.sv */
// Bucket head memory with a sweep that clears it after reset.
`default_nettype none
module tfnm_bucket_ram (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [tfnm_pkg::NodeBits-1:0] raddr_i,
  output tfnm_pkg::link_t              rdata_o,
  input  wire                          we_i,
  input  wire [tfnm_pkg::NodeBits-1:0] waddr_i,
  input  tfnm_pkg::link_t              wdata_i,
  output logic                         ready_o
);
  tfnm_pkg::link_t mem [2**tfnm_pkg::NodeBits];
  logic [tfnm_pkg::NodeBits:0] clr_q;
  logic                        clr_done;

  assign clr_done = clr_q[tfnm_pkg::NodeBits];
  assign ready_o  = clr_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (!clr_done) begin
      clr_q <= clr_q + (tfnm_pkg::NodeBits+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!clr_done) begin
      mem[clr_q[tfnm_pkg::NodeBits-1:0]] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/tfnm_face_ram.sv */
// Face table memory: one read and one write port, registered read data.
`default_nettype none
module tfnm_face_ram (
  input  wire                                  clk_i,
  input  wire [tfnm_pkg::FaceBits-1:0]         raddr_i,
  output tfnm_pkg::face_ent_t                  rdata_o,
  input  wire                                  we_i,
  input  wire [tfnm_pkg::FaceBits-1:0]         waddr_i,
  input  tfnm_pkg::face_ent_t                  wdata_i
);
  tfnm_pkg::face_ent_t mem [tfnm_pkg::MaxFaces];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* sv/tet_face_neighbor_matcher.sv */
// Top level of the tetrahedral face matcher: control sequencer and memories.
// Each face walks the Face, Head and Read states, then a Check and Read pair per chain entry
// that does not match, a Check for a matching entry, and Done; its result comes in Done,
// its last state. The four faces run back to back, then Idle takes the next item; busy is
// high meanwhile.
// Reset empties all buckets by a clearing pass, with busy high; no stalls.
`default_nettype none
module tet_face_neighbor_matcher (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  output logic                  busy,
  input  tfnm_pkg::in_item_t    in_item_i,
  output logic                  res_valid_o,
  output tfnm_pkg::out_item_t   res_item_o
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFace  = 3'd1;  // form face, read bucket head
  localparam logic [2:0] StHead  = 3'd2;  // bucket head data available
  localparam logic [2:0] StRead  = 3'd3;  // face entry read issued
  localparam logic [2:0] StCheck = 3'd4;  // face entry data available
  localparam logic [2:0] StDone  = 3'd5;  // finish the face

  logic [2:0] st_q, st_d;
  tfnm_pkg::in_item_t in_q;
  logic [1:0]  slot_q, slot_d;
  logic [15:0] f0_q, f1_q, f2_q, mn_q;
  logic [tfnm_pkg::FaceBits:0] count_q, count_d;
  tfnm_pkg::link_t head_q, head_d;   // bucket head captured for this face
  tfnm_pkg::link_t cur_q, cur_d;     // chain position being visited
  logic found_q, found_d;
  logic [tfnm_pkg::FaceBits-1:0] hit_q, hit_d;
  tfnm_pkg::face_ent_t hit_ent_q, hit_ent_d;

  tfnm_pkg::link_t     bk_rdata, bk_wdata;
  logic                bk_we, bk_ready;
  tfnm_pkg::face_ent_t fc_rdata, fc_wdata;
  logic                fc_we;
  logic [tfnm_pkg::FaceBits-1:0] fc_waddr;

  logic [15:0] vsel [4];
  logic [15:0] fa, fb, fc, m01, mn;
  logic        covers;
  logic        e_ok;

  assign vsel[0] = in_q.vertex_a;
  assign vsel[1] = in_q.vertex_b;
  assign vsel[2] = in_q.vertex_c;
  assign vsel[3] = in_q.vertex_d;
  assign fa  = vsel[tfnm_pkg::face_vtx(slot_q, 2'd0)];
  assign fb  = vsel[tfnm_pkg::face_vtx(slot_q, 2'd1)];
  assign fc  = vsel[tfnm_pkg::face_vtx(slot_q, 2'd2)];
  assign m01 = (fa < fb) ? fa : fb;
  assign mn  = (m01 < fc) ? m01 : fc;

  // The entry covers the face when each stored vertex is one of the face's.
  assign covers =
    ((fc_rdata.v0 == f0_q) || (fc_rdata.v0 == f1_q) || (fc_rdata.v0 == f2_q)) &&
    ((fc_rdata.v1 == f0_q) || (fc_rdata.v1 == f1_q) || (fc_rdata.v1 == f2_q)) &&
    ((fc_rdata.v2 == f0_q) || (fc_rdata.v2 == f1_q) || (fc_rdata.v2 == f2_q));

  // Only entries below the fill count exist.
  assign e_ok = cur_q.vld && ({1'b0, cur_q.idx} < count_q);

  tfnm_bucket_ram u_bucket (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (mn),
    .rdata_o (bk_rdata),
    .we_i    (bk_we),
    .waddr_i (mn_q),
    .wdata_i (bk_wdata),
    .ready_o (bk_ready)
  );

  tfnm_face_ram u_face (
    .clk_i   (clk_i),
    .raddr_i (cur_q.idx),
    .rdata_o (fc_rdata),
    .we_i    (fc_we),
    .waddr_i (fc_waddr),
    .wdata_i (fc_wdata)
  );

  assign busy = (st_q != StIdle) || !bk_ready;

  always_comb begin
    st_d      = st_q;
    slot_d    = slot_q;
    count_d   = count_q;
    head_d    = head_q;
    cur_d     = cur_q;
    found_d   = found_q;
    hit_d     = hit_q;
    hit_ent_d = hit_ent_q;
    bk_we     = 1'b0;
    bk_wdata  = '0;
    fc_we     = 1'b0;
    fc_waddr  = hit_q;
    fc_wdata  = hit_ent_q;
    res_valid_o = 1'b0;
    res_item_o  = '0;
    res_item_o.own_cell  = in_q.cell_number;
    res_item_o.own_slot  = slot_q;
    res_item_o.last_face = (slot_q == 2'd3);

    unique case (st_q)
      StIdle: begin
        if (start && bk_ready) begin
          slot_d = 2'd0;
          st_d   = StFace;
        end
      end
      StFace: begin
        // The bucket read is addressed by mn this cycle.
        found_d = 1'b0;
        st_d    = StHead;
      end
      StHead: begin
        head_d = bk_rdata;
        cur_d  = bk_rdata;
        st_d   = StRead;
      end
      StRead: begin
        if (e_ok) begin
          st_d = StCheck;
        end else begin
          st_d = StDone;
        end
      end
      StCheck: begin
        if (covers) begin
          found_d   = 1'b1;
          hit_d     = cur_q.idx;
          hit_ent_d = fc_rdata;
          st_d      = StDone;
        end else begin
          cur_d = fc_rdata.next;
          st_d  = StRead;
        end
      end
      StDone: begin
        res_valid_o = 1'b1;
        if (found_q) begin
          if (hit_ent_q.shared) begin
            res_item_o.face_status = tfnm_pkg::StatusShared;
          end else begin
            res_item_o.face_status = tfnm_pkg::StatusMatch;
            res_item_o.other_cell  = hit_ent_q.owner_cell;
            res_item_o.other_slot  = hit_ent_q.slot;
            fc_we           = 1'b1;
            fc_waddr        = hit_q;
            fc_wdata        = hit_ent_q;
            fc_wdata.shared = 1'b1;
          end
        end else if (count_q >= (tfnm_pkg::FaceBits+1)'(tfnm_pkg::MaxFaces)) begin
          res_item_o.face_status = tfnm_pkg::StatusFull;
        end else begin
          res_item_o.face_status = tfnm_pkg::StatusNew;
          fc_we         = 1'b1;
          fc_waddr      = count_q[tfnm_pkg::FaceBits-1:0];
          fc_wdata.v0   = f0_q;
          fc_wdata.v1   = f1_q;
          fc_wdata.v2   = f2_q;
          fc_wdata.owner_cell = in_q.cell_number;
          fc_wdata.slot = slot_q;
          fc_wdata.shared = 1'b0;
          fc_wdata.next = head_q;
          bk_we         = 1'b1;
          bk_wdata.vld  = 1'b1;
          bk_wdata.idx  = count_q[tfnm_pkg::FaceBits-1:0];
          count_d       = count_q + (tfnm_pkg::FaceBits+1)'(1);
        end
        slot_d = slot_q + 2'd1;
        st_d   = (slot_q == 2'd3) ? StIdle : StFace;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      count_q <= '0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && start && bk_ready) begin
      in_q <= in_item_i;
    end
    if (st_q == StFace) begin
      f0_q <= fa;
      f1_q <= fb;
      f2_q <= fc;
      mn_q <= mn;
    end
    slot_q    <= slot_d;
    head_q    <= head_d;
    cur_q     <= cur_d;
    found_q   <= found_d;
    hit_q     <= hit_d;
    hit_ent_q <= hit_ent_d;
  end
endmodule
`default_nettype wire
